@@ hdl/wcr_pkg.sv @@
package wcr_pkg;

  // Default framebuffer geometry
  localparam int MAX_COLUMNS_DEF = 512;
  localparam int MAX_ROWS_DEF    = 256;

  // Fixed field widths
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 16;
  localparam int DELTA_W    = 17;
  localparam int COLOR_W    = 24;
  localparam int RCOL_W     = 9;
  localparam int RROW_W     = 8;
  localparam int VW_W       = 10;
  localparam int VH_W       = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int CLAMP_W    = 48;

  localparam logic [9:0] SCR_COLS_RST = 10'd320;
  localparam logic [8:0] SCR_ROWS_RST = 9'd240;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_ROWS = 1'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic add;
    logic dst;
    logic store_y;
    logic yset;
    logic prd;
    logic pwr;
    logic ystep;
    logic xstep;
    logic rrd;
    logic out_load;
    logic out_rd;
    logic clr_wr;
    logic sel;
  } wcr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic y_last;
    logic x_last;
    logic clr_last;
    logic out_free;
  } wcr_sts_t;

  // Clamp a signed value into [0, hi]
  function automatic logic [CLAMP_W-1:0] clamp_hi(input logic signed [CLAMP_W-1:0] v,
                                                  input logic [CLAMP_W-1:0] hi);
    logic [CLAMP_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if ($unsigned(v) > hi) begin
      r = hi;
    end else begin
      r = $unsigned(v);
    end
    return r;
  endfunction

endpackage

@@ hdl/wcr_if.sv @@
interface wcr_in_if;
  import wcr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [COORD_W-1:0] x_start;
  logic signed [COORD_W-1:0] x_end;
  logic signed [COORD_W-1:0] bottom_start;
  logic signed [COORD_W-1:0] bottom_end;
  logic signed [COORD_W-1:0] top_start;
  logic signed [COORD_W-1:0] top_end;
  logic [COLOR_W-1:0]        wall_color;
  logic [RCOL_W-1:0]         read_column;
  logic [RROW_W-1:0]         read_row;

  modport source (output valid, kind, x_start, x_end, bottom_start, bottom_end, top_start,
                  top_end, wall_color, read_column, read_row, input ready);
  modport sink (input valid, kind, x_start, x_end, bottom_start, bottom_end, top_start,
                top_end, wall_color, read_column, read_row, output ready);
endinterface

interface wcr_out_if;
  import wcr_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface

interface wcr_cfg_if;
  import wcr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/wcr_div.sv @@
module wcr_div
  import wcr_pkg::*;
#(
  parameter int NW = 36
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [NW-1:0]       dividend,
  input  logic signed [DELTA_W-1:0]  divisor,
  output logic                       busy,
  output logic signed [NW:0]         quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic               busy_r, busy_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [NW-1:0]      quo_r, quo_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;
  logic [DELTA_W-1:0] den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic [DELTA_W:0]   shifted;
  logic [DELTA_W:0]   diff;

  // One quotient bit per cycle, restoring on magnitudes
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[NW-1]};
    diff     = shifted - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(NW);
      quo_nxt  = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      den_nxt  = divisor[DELTA_W-1] ? DELTA_W'(-divisor) : DELTA_W'(divisor);
      rem_nxt  = '0;
      neg_nxt  = dividend[NW-1] ^ divisor[DELTA_W-1];
    end else if (busy_r) begin
      if (!diff[DELTA_W]) begin
        rem_nxt = diff[DELTA_W-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DELTA_W-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Restore sign, truncated toward zero
  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

@@ hdl/wcr_ctrl.sv @@
module wcr_ctrl
  import wcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  wcr_sts_t          sts,
  output wcr_cmd_t          cmd
);

  localparam logic [3:0] S_BOOT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_DST   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_YSET  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PWR   = 4'd9;
  localparam logic [3:0] S_RRD   = 4'd10;
  localparam logic [3:0] S_ROUT  = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;

  // Sequence one request through the datapath
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd.sel   = sel_r;
    case (state_r)
      S_BOOT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_kind)
            KIND_WALL:  state_nxt = S_SETUP;
            KIND_READ:  state_nxt = S_RRD;
            KIND_CLEAR: state_nxt = S_CLR;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        sel_nxt   = 1'b0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DST;
      end
      S_DST: begin
        cmd.dst   = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts.div_busy) begin
          cmd.store_y = 1'b1;
          if (sel_r) begin
            state_nxt = S_YSET;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_YSET: begin
        cmd.yset  = 1'b1;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd.prd   = 1'b1;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.pwr = 1'b1;
        if (sts.y_last) begin
          if (sts.x_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.xstep = 1'b1;
            sel_nxt   = 1'b0;
            state_nxt = S_MUL;
          end
        end else begin
          cmd.ystep = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_RRD: begin
        cmd.rrd   = 1'b1;
        state_nxt = S_ROUT;
      end
      S_ROUT: begin
        // Hold the read address so the read data survives a wait
        cmd.rrd = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_rd   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ hdl/wcr_dp.sv @@
module wcr_dp
  import wcr_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wcr_cmd_t                  cmd,
  output wcr_sts_t                  sts,
  input  logic signed [COORD_W-1:0] x_start,
  input  logic signed [COORD_W-1:0] x_end,
  input  logic signed [COORD_W-1:0] bottom_start,
  input  logic signed [COORD_W-1:0] bottom_end,
  input  logic signed [COORD_W-1:0] top_start,
  input  logic signed [COORD_W-1:0] top_end,
  input  logic [COLOR_W-1:0]        wall_color,
  input  logic [RCOL_W-1:0]         read_column,
  input  logic [RROW_W-1:0]         read_row,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COLOR_W-1:0]        out_pixel
);

  localparam int XW    = $clog2(MAX_COLUMNS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int WW    = $clog2(MAX_COLUMNS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OFFW  = ((XW + 1 > COORD_W + 1) ? XW + 1 : COORD_W + 1) + 1;
  localparam int PAW   = COORD_W + DELTA_W;
  localparam int PBW   = DELTA_W + OFFW;
  localparam int NW    = PBW + 1;

  // View registers
  logic [VW_W-1:0] scr_cols_r;
  logic [VH_W-1:0] scr_rows_r;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [XW-1:0]   wm1;
  logic [YW-1:0]   hm1;

  // Latched request
  logic signed [COORD_W-1:0] x1_r, x2_r, b1_r, b2_r, t1_r, t2_r;
  logic [COLOR_W-1:0]        color_r;
  logic [RCOL_W-1:0]         rcol_r;
  logic [RROW_W-1:0]         rrow_r;

  // Walk state
  logic signed [DELTA_W-1:0] dx_r, db_r, dt_r, dx_raw;
  logic                      xdir_r, ydir_r;
  logic [XW-1:0]             x_r, cx2_r;
  logic [YW-1:0]             y_r, cyt_r;
  logic signed [OFFW-1:0]    off;
  logic signed [COORD_W-1:0] m_row;
  logic signed [DELTA_W-1:0] m_delta;
  logic signed [PAW-1:0]     pa_r;
  logic signed [PBW-1:0]     pb_r;
  logic signed [NW-1:0]      num_r;
  logic signed [NW:0]        yb_r, yt_r, quo;
  logic                      div_busy;
  logic                      inview_r;

  // Store and clear sweep
  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      pix_addr, rd_addr, wr_addr;
  logic [COLOR_W-1:0] wr_data;
  logic               we;
  logic               clr_last;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_pixel_r;

  // Effective view size
  always_comb begin
    if (scr_cols_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(scr_cols_r) > 32'(MAX_COLUMNS)) begin
      w_eff = WW'(MAX_COLUMNS);
    end else begin
      w_eff = WW'(scr_cols_r);
    end
    if (scr_rows_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(scr_rows_r) > 32'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(scr_rows_r);
    end
  end

  assign wm1 = XW'(w_eff - 1'b1);
  assign hm1 = YW'(h_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_cols_r <= SCR_COLS_RST;
      scr_rows_r <= SCR_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCR_COLS: scr_cols_r <= cfg_data[VW_W-1:0];
        CFG_SCR_ROWS: scr_rows_r <= cfg_data[VH_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r    <= x_start;
      x2_r    <= x_end;
      b1_r    <= bottom_start;
      b2_r    <= bottom_end;
      t1_r    <= top_start;
      t2_r    <= top_end;
      color_r <= wall_color;
      rcol_r  <= read_column;
      rrow_r  <= read_row;
    end
  end

  assign dx_raw  = DELTA_W'(x2_r) - DELTA_W'(x1_r);
  assign off     = OFFW'($signed({1'b0, x_r})) - OFFW'(x1_r);
  assign m_row   = cmd.sel ? t1_r : b1_r;
  assign m_delta = cmd.sel ? dt_r : db_r;

  // Column walk: set up, multiply, sum, divide, clamp
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      dx_r   <= (dx_raw == '0) ? DELTA_W'(1) : dx_raw;
      db_r   <= DELTA_W'(b2_r) - DELTA_W'(b1_r);
      dt_r   <= DELTA_W'(t2_r) - DELTA_W'(t1_r);
      xdir_r <= (x1_r < x2_r);
      x_r    <= XW'(clamp_hi(CLAMP_W'(x1_r), CLAMP_W'(wm1)));
      cx2_r  <= XW'(clamp_hi(CLAMP_W'(x2_r), CLAMP_W'(wm1)));
    end else if (cmd.xstep) begin
      x_r <= xdir_r ? x_r + 1'b1 : x_r - 1'b1;
    end
    if (cmd.mul) begin
      pa_r <= m_row * dx_r;
      pb_r <= m_delta * off;
    end
    if (cmd.add) begin
      num_r <= NW'(pa_r) + NW'(pb_r);
    end
    if (cmd.store_y) begin
      if (cmd.sel) yt_r <= quo;
      else         yb_r <= quo;
    end
    if (cmd.yset) begin
      ydir_r <= (yb_r < yt_r);
      y_r    <= YW'(clamp_hi(CLAMP_W'(yb_r), CLAMP_W'(hm1)));
      cyt_r  <= YW'(clamp_hi(CLAMP_W'(yt_r), CLAMP_W'(hm1)));
    end else if (cmd.ystep) begin
      y_r <= ydir_r ? y_r + 1'b1 : y_r - 1'b1;
    end
    if (cmd.rrd) begin
      inview_r <= (32'(rcol_r) < 32'(w_eff)) && (32'(rrow_r) < 32'(h_eff));
    end
  end

  wcr_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.dst),
    .dividend (num_r),
    .divisor  (dx_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Store addressing
  assign pix_addr = AW'(32'(y_r) * 32'(MAX_COLUMNS) + 32'(x_r));
  assign rd_addr  = cmd.rrd ? AW'(32'(rrow_r) * 32'(MAX_COLUMNS) + 32'(rcol_r)) : pix_addr;
  assign clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  // Clear writes zero; a pixel writes only while the stored red byte is zero
  always_comb begin
    we      = 1'b0;
    wr_addr = pix_addr;
    wr_data = color_r;
    if (cmd.clr_wr) begin
      we      = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.pwr && (rdata_r[23:16] == 8'd0)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // Clear sweep counter wraps to zero at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_pixel_r <= (cmd.out_rd && inview_r) ? rdata_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  assign sts.div_busy = div_busy;
  assign sts.y_last   = (y_r == cyt_r);
  assign sts.x_last   = (x_r == cx2_r);
  assign sts.clr_last = clr_last;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

@@ hdl/wall_column_rasterizer.sv @@
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   kind, x/bottom/top ends, wall_color, read_column, read_row
// out_ch   out  valid/ready   pixel_color (one per request)
// cfg_ch   in   valid/ready   index, data (screen columns, screen rows); always ready
//
// Wall: per column two serial divides (NW about 36), then for each filled pixel
//   a store read followed by a conditional write.
// Read: a store read, then a result load. Clear: MAX_COLUMNS*MAX_ROWS entries, one per cycle.
// After reset a clearing pass over all MAX_COLUMNS*MAX_ROWS entries runs before in_ch is ready.
// A waiting result holds in its register while the next request is taken.
module wall_column_rasterizer
  import wcr_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  wcr_in_if.sink         in_ch,
  wcr_out_if.source      out_ch,
  wcr_cfg_if.sink        cfg_ch
);

  wcr_cmd_t cmd;
  wcr_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  wcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wcr_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .x_start      (in_ch.x_start),
    .x_end        (in_ch.x_end),
    .bottom_start (in_ch.bottom_start),
    .bottom_end   (in_ch.bottom_end),
    .top_start    (in_ch.top_start),
    .top_end      (in_ch.top_end),
    .wall_color   (in_ch.wall_color),
    .read_column  (in_ch.read_column),
    .read_row     (in_ch.read_row),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_pixel    (out_ch.pixel_color)
  );

`ifndef NO_ASSERTIONS
  // A result loads only into a free result register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result loaded over pending result");

  // Divider must report busy after a start
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dst |=> sts.div_busy) else $error("divider did not start");

  // Column step never passes the last column
  a_x_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.xstep |-> !sts.x_last) else $error("column step past last column");
`endif

endmodule
